// File: hw/rtl/ecra_pkg.sv
package ecra_pkg;

   // Fixed field widths
   localparam int PORT_W   = 16;
   localparam int WAIT_W   = 20;
   localparam int VALUE_W  = 64;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 2;

   // Default access size limit (bytes per request)
   localparam int MAX_BYTES_DEF = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_PORT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAT_PORT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT   = 2'd2;

   // Register reset values
   localparam logic [PORT_W-1:0] COMMAND_PORT_RST = 16'h0066;
   localparam logic [PORT_W-1:0] DAT_PORT_RST     = 16'h0062;
   localparam logic [WAIT_W-1:0] WAIT_LIMIT_RST   = 20'd5000;

   // Request kinds
   localparam logic [1:0] KIND_ACCESS = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   // Result actions
   localparam logic [1:0] ACT_READ_STATUS = 2'd0;
   localparam logic [1:0] ACT_WRITE_BYTE  = 2'd1;
   localparam logic [1:0] ACT_READ_DATA   = 2'd2;
   localparam logic [1:0] ACT_DONE        = 2'd3;

   // Result codes
   localparam logic RC_OK      = 1'b0;
   localparam logic RC_TIMEOUT = 1'b1;

   // Result queue sizing
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [PORT_W-1:0] command_port;
      logic [PORT_W-1:0] dat_port;
      logic [WAIT_W-1:0] wait_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [PORT_W-1:0]  port;
      logic [7:0]         out_byte;
      logic               result_code;
      logic [VALUE_W-1:0] read_value;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic rsp_item_type make_item(
      input logic [1:0]         action,
      input logic [PORT_W-1:0]  port,
      input logic [7:0]         out_byte,
      input logic               result_code,
      input logic [VALUE_W-1:0] read_value
   );
      rsp_item_type it;
      it.action      = action;
      it.port        = port;
      it.out_byte    = out_byte;
      it.result_code = result_code;
      it.read_value  = read_value;
      it.last        = 1'b0;
      return it;
   endfunction

endpackage

// File: hw/rtl/ecra_core.sv
module ecra_core #(
   parameter int MAX_BYTES = ecra_pkg::MAX_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [1:0]                    kind,
   input  logic                          is_write,
   input  logic [15:0]                   offset,
   input  logic [3:0]                    width,
   input  logic [63:0]                   write_value,
   input  logic [7:0]                    bus_byte,
   input  ecra_pkg::cfg_type             cfg,
   output ecra_pkg::push_type            push
);

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_WAIT_CMD  = 4'd1;
   localparam logic [3:0] PH_WAIT_ADDR = 4'd2;
   localparam logic [3:0] PH_WAIT_OBF  = 4'd3;
   localparam logic [3:0] PH_READ_DATA = 4'd4;
   localparam logic [3:0] PH_WAIT_VAL  = 4'd5;
   localparam logic [3:0] PH_WAIT_FIN  = 4'd6;

   localparam logic [3:0]  MAX_W       = 4'(MAX_BYTES);
   localparam logic [7:0]  ST_OBF      = 8'h01;
   localparam logic [7:0]  ST_IBF      = 8'h02;
   localparam logic [7:0]  CMD_READ    = 8'h80;
   localparam logic [7:0]  CMD_WRITE   = 8'h81;
   localparam logic [7:0]  OPEN_BUS    = 8'hFF;
   localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic [15:0] base_offset_ff, base_offset_in;
   logic [3:0]  access_bytes_ff, access_bytes_in;
   logic        writing_ff, writing_in;
   logic [63:0] write_data_ff, write_data_in;
   logic [63:0] gathered_ff, gathered_in;
   logic [19:0] wait_elapsed_ff, wait_elapsed_in;

   logic                   waiting;
   logic                   status_ok;
   logic [3:0]             req_bytes;
   logic [3:0]             next_index;
   logic                   more_bytes;
   logic [5:0]             lane_shift;
   logic [63:0]            gathered_rd;
   logic [7:0]             cur_addr;
   logic [7:0]             cur_wbyte;
   ecra_pkg::rsp_item_type poll_item;
   ecra_pkg::push_type     push_c;

   always_comb begin
      waiting = (phase_ff == PH_WAIT_CMD) || (phase_ff == PH_WAIT_ADDR) ||
                (phase_ff == PH_WAIT_OBF) || (phase_ff == PH_WAIT_VAL) ||
                (phase_ff == PH_WAIT_FIN);
      status_ok = (phase_ff == PH_WAIT_OBF) ? ((bus_byte & ST_OBF) == ST_OBF)
                                            : ((bus_byte & ST_IBF) == 8'h00);
      if (width == 4'd0) begin
         req_bytes = 4'd1;
      end else if (width > MAX_W) begin
         req_bytes = MAX_W;
      end else begin
         req_bytes = width;
      end
      next_index  = byte_index_ff + 4'd1;
      more_bytes  = (next_index < access_bytes_ff) &&
                    ((17'(base_offset_ff) + 17'(next_index)) <= 17'd255);
      lane_shift  = {byte_index_ff[2:0], 3'b000};
      gathered_rd = gathered_ff | (64'(bus_byte) << lane_shift);
      cur_addr    = 8'(base_offset_ff + 16'(byte_index_ff));
      cur_wbyte   = 8'(write_data_ff >> lane_shift);
      poll_item   = ecra_pkg::make_item(ecra_pkg::ACT_READ_STATUS, cfg.command_port,
                                        8'h00, ecra_pkg::RC_OK, 64'd0);
   end

   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      base_offset_in  = base_offset_ff;
      access_bytes_in = access_bytes_ff;
      writing_in      = writing_ff;
      write_data_in   = write_data_ff;
      gathered_in     = gathered_ff;
      wait_elapsed_in = wait_elapsed_ff;
      push_c          = '0;

      if (fire) begin
         unique case (kind)
            ecra_pkg::KIND_ACCESS: begin
               if (phase_ff == PH_IDLE) begin
                  writing_in      = is_write;
                  base_offset_in  = offset;
                  access_bytes_in = req_bytes;
                  write_data_in   = write_value;
                  gathered_in     = 64'd0;
                  byte_index_in   = 4'd0;
                  push_c.count    = 2'd1;
                  if (offset > 16'd255) begin
                     // nothing addressable: complete at once, value zero
                     push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_DONE, 16'd0, 8'h00,
                                                        ecra_pkg::RC_OK, 64'd0);
                  end else begin
                     phase_in        = PH_WAIT_CMD;
                     wait_elapsed_in = 20'd0;
                     push_c.item0    = poll_item;
                  end
               end
            end
            ecra_pkg::KIND_TICK: begin
               if (waiting && (wait_elapsed_ff != ELAPSED_MAX)) begin
                  wait_elapsed_in = wait_elapsed_ff + 20'd1;
               end
            end
            ecra_pkg::KIND_DATA: begin
               if (phase_ff == PH_READ_DATA) begin
                  gathered_in   = gathered_rd;
                  byte_index_in = next_index;
                  push_c.count  = 2'd1;
                  if (more_bytes) begin
                     phase_in        = PH_WAIT_CMD;
                     wait_elapsed_in = 20'd0;
                     push_c.item0    = poll_item;
                  end else begin
                     phase_in     = PH_IDLE;
                     push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_DONE, 16'd0, 8'h00,
                                       ecra_pkg::RC_OK, writing_ff ? 64'd0 : gathered_rd);
                  end
               end
            end
            ecra_pkg::KIND_STATUS: begin
               if (waiting) begin
                  push_c.count = 2'd1;
                  if (bus_byte == OPEN_BUS) begin
                     phase_in     = PH_IDLE;
                     push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_DONE, 16'd0, 8'h00,
                                                        ecra_pkg::RC_TIMEOUT, 64'd0);
                  end else if (!status_ok) begin
                     if (wait_elapsed_ff >= cfg.wait_limit) begin
                        phase_in     = PH_IDLE;
                        push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_DONE, 16'd0,
                                          8'h00, ecra_pkg::RC_TIMEOUT, 64'd0);
                     end else begin
                        push_c.item0 = poll_item;
                     end
                  end else begin
                     unique case (phase_ff)
                        PH_WAIT_CMD: begin
                           push_c.count    = 2'd2;
                           push_c.item0    = ecra_pkg::make_item(ecra_pkg::ACT_WRITE_BYTE,
                                                cfg.command_port,
                                                writing_ff ? CMD_WRITE : CMD_READ,
                                                ecra_pkg::RC_OK, 64'd0);
                           push_c.item1    = poll_item;
                           phase_in        = PH_WAIT_ADDR;
                           wait_elapsed_in = 20'd0;
                        end
                        PH_WAIT_ADDR: begin
                           push_c.count    = 2'd2;
                           push_c.item0    = ecra_pkg::make_item(ecra_pkg::ACT_WRITE_BYTE,
                                                cfg.dat_port, cur_addr,
                                                ecra_pkg::RC_OK, 64'd0);
                           push_c.item1    = poll_item;
                           phase_in        = writing_ff ? PH_WAIT_VAL : PH_WAIT_OBF;
                           wait_elapsed_in = 20'd0;
                        end
                        PH_WAIT_OBF: begin
                           phase_in     = PH_READ_DATA;
                           push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_READ_DATA,
                                             cfg.dat_port, 8'h00, ecra_pkg::RC_OK, 64'd0);
                        end
                        PH_WAIT_VAL: begin
                           push_c.count    = 2'd2;
                           push_c.item0    = ecra_pkg::make_item(ecra_pkg::ACT_WRITE_BYTE,
                                                cfg.dat_port, cur_wbyte,
                                                ecra_pkg::RC_OK, 64'd0);
                           push_c.item1    = poll_item;
                           phase_in        = PH_WAIT_FIN;
                           wait_elapsed_in = 20'd0;
                        end
                        default: begin
                           // final IBF-clear wait of a write byte
                           byte_index_in = next_index;
                           if (more_bytes) begin
                              phase_in        = PH_WAIT_CMD;
                              wait_elapsed_in = 20'd0;
                              push_c.item0    = poll_item;
                           end else begin
                              phase_in     = PH_IDLE;
                              push_c.item0 = ecra_pkg::make_item(ecra_pkg::ACT_DONE,
                                                16'd0, 8'h00, ecra_pkg::RC_OK,
                                                writing_ff ? 64'd0 : gathered_ff);
                           end
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      if (push_c.count == 2'd1) begin
         push_c.item0.last = 1'b1;
      end else if (push_c.count == 2'd2) begin
         push_c.item1.last = 1'b1;
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         wait_elapsed_ff <= 20'd0;
      end else begin
         phase_ff        <= phase_in;
         wait_elapsed_ff <= wait_elapsed_in;
      end
      byte_index_ff   <= byte_index_in;
      base_offset_ff  <= base_offset_in;
      access_bytes_ff <= access_bytes_in;
      writing_ff      <= writing_in;
      write_data_ff   <= write_data_in;
      gathered_ff     <= gathered_in;
   end

endmodule

// File: hw/rtl/ecra_rspq.sv
module ecra_rspq (
   input  logic                   clock,
   input  logic                   reset,
   input  ecra_pkg::push_type     push,
   input  logic                   pop,
   output logic                   not_empty,
   output logic                   has_room,
   output ecra_pkg::rsp_item_type head_item
);

   localparam int DEPTH = ecra_pkg::RSPQ_DEPTH;
   localparam int PTR_W = ecra_pkg::RSPQ_PTR_W;
   localparam int CNT_W = ecra_pkg::RSPQ_CNT_W;

   ecra_pkg::rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] tail0, tail1;

   always_comb begin
      tail0     = head_ff + PTR_W'(count_ff);
      tail1     = tail0 + PTR_W'(1);
      not_empty = (count_ff != '0);
      // room for the two results one request may leave
      has_room  = (count_ff <= CNT_W'(DEPTH - 2));
      head_item = entry_ff[head_ff];
      head_in   = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[tail0] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail1] <= push.item1;
      end
   end

endmodule

// File: hw/rtl/ec_region_access_engine.sv
// Host-side embedded-controller access engine. Each request on the req_ channel is
// one event: an access request (read or write of 1..MAX_BYTES controller
// addresses), a sampled status byte, a data byte read back, or a timer tick.
// The engine answers with bus actions on the rsp_ channel (read status, write a
// byte to a port, read the data port) and a final done carrying the result code
// and gathered read data; rsp_last marks the final result of each request.
// Events that make no sense in the current phase are dropped without a result.
// Rate: one request per cycle while req_stall is low. Each request leaves
// zero, one or two results in a four-entry result queue, which sends one
// result per cycle on rsp_ while rsp_stall is low. req_stall rises only while
// the queue holds more than two results, so a slow consumer or a run of
// two-result requests sets the pace. The user must write port and limit registers
// through csr_ only while the engine is idle; the block does not enforce it.
module ec_region_access_engine #(
   parameter int MAX_BYTES = ecra_pkg::MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic        req_is_write,
   input  logic [15:0] req_offset,
   input  logic [3:0]  req_width,
   input  logic [63:0] req_write_value,
   input  logic [7:0]  req_bus_byte,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [15:0] rsp_port,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_result_code,
   output logic [63:0] rsp_read_value,
   output logic        rsp_last
);

   ecra_pkg::cfg_type      cfg_ff, cfg_in;
   ecra_pkg::push_type     push;
   ecra_pkg::rsp_item_type head_item;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   q_room;
   logic                   q_not_empty;

   // Config registers; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ecra_pkg::CSR_COMMAND_PORT: cfg_in.command_port = csr_wdata[15:0];
            ecra_pkg::CSR_DAT_PORT:     cfg_in.dat_port     = csr_wdata[15:0];
            ecra_pkg::CSR_WAIT_LIMIT:   cfg_in.wait_limit   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_port <= ecra_pkg::COMMAND_PORT_RST;
         cfg_ff.dat_port     <= ecra_pkg::DAT_PORT_RST;
         cfg_ff.wait_limit   <= ecra_pkg::WAIT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshakes: stall depends only on queue fill, never on valid.
   assign req_stall = !q_room;
   assign req_fire  = req_valid && q_room;
   assign rsp_valid = q_not_empty;
   assign rsp_fire  = q_not_empty && !rsp_stall;

   // Phase tracking and result generation for one event per cycle.
   ecra_core #(
      .MAX_BYTES(MAX_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .kind        (req_kind),
      .is_write    (req_is_write),
      .offset      (req_offset),
      .width       (req_width),
      .write_value (req_write_value),
      .bus_byte    (req_bus_byte),
      .cfg         (cfg_ff),
      .push        (push)
   );

   // Result queue: absorbs two-result events and decouples rsp_stall.
   ecra_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_fire),
      .not_empty (q_not_empty),
      .has_room  (q_room),
      .head_item (head_item)
   );

   assign rsp_action      = head_item.action;
   assign rsp_port        = head_item.port;
   assign rsp_out_byte    = head_item.out_byte;
   assign rsp_result_code = head_item.result_code;
   assign rsp_read_value  = head_item.read_value;
   assign rsp_last        = head_item.last;

endmodule
